// ===== design/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg: shared types and constants of the ellipse tile row span core
// Holds the mode codes, register indexes, shape classes and the sideband
// record that travels with each beat down the pipeline.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned TILE_WIDTH_RST = 64;
  localparam int unsigned TILE_HEIGHT_RST = 64;
  localparam int unsigned CFG_INDEX_BITS = 1;

  typedef enum logic [3:0] {
    MODE_UL     = 4'd0,
    MODE_UR     = 4'd1,
    MODE_LL     = 4'd2,
    MODE_LR     = 4'd3,
    MODE_TOP    = 4'd4,
    MODE_BOTTOM = 4'd5,
    MODE_LEFT   = 4'd6,
    MODE_RIGHT  = 4'd7,
    MODE_FULL   = 4'd8
  } mode_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TILE_WIDTH  = 1'b0,
    REG_TILE_HEIGHT = 1'b1
  } reg_idx_e;

  // How the quotient maps onto the span.
  typedef enum logic [1:0] {
    SHAPE_LEFT,    // [0, q)
    SHAPE_RIGHT,   // [w-q, w)
    SHAPE_CENTER,  // [q, w-q)
    SHAPE_FULL     // [qa, qb)
  } shape_e;

  typedef struct packed {
    shape_e shape;
    logic   empty;
    logic   inv;
  } side_t;

endpackage

// ===== design/ets_front.sv =====
// ----------------------------------------------------------------------------
// ets_front: operand stages of the span pipeline
// Decodes the mode, forms the radicand factor D and the products w*w and
// w*h in the first stage, and the radicand w*w*D in the second.
// ----------------------------------------------------------------------------
module ets_front #(
  parameter int unsigned COORD_BITS = ets_pkg::COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [3:0]                mode_i,
  input  logic [COORD_BITS-1:0]     row_i,
  input  logic                      invert_i,
  input  logic [COORD_BITS-1:0]     w_i,
  input  logic [COORD_BITS-1:0]     h_i,
  output logic                      valid_o,
  output ets_pkg::side_t            side_o,
  output logic [4*COORD_BITS-1:0]   x_o,
  output logic [2*COORD_BITS-1:0]   wh_o
);
  import ets_pkg::*;

  localparam int unsigned DW = 2 * COORD_BITS;
  localparam int unsigned XW = 4 * COORD_BITS;
  localparam int unsigned OW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * OW;

  logic [COORD_BITS-1:0] yf, yy;
  logic [OW-1:0]         op_a, op_b;
  logic [PW-1:0]         prod;
  logic [DW-1:0]         d_d, ww_d, wh_d;
  shape_e                shape;
  logic                  mirror, sel_left, sel_full, bad_mode;
  side_t                 side_d;

  logic                  s1_valid_q, s2_valid_q;
  side_t                 s1_side_q, s2_side_q;
  logic [DW-1:0]         s1_d_q, s1_ww_q, s1_wh_q, s2_wh_q;
  logic [XW-1:0]         s2_x_q;

  always_comb begin
    shape    = SHAPE_LEFT;
    mirror   = 1'b0;
    sel_left = 1'b0;
    sel_full = 1'b0;
    bad_mode = 1'b0;
    unique case (mode_i)
      MODE_UL:     shape = SHAPE_LEFT;
      MODE_UR:     shape = SHAPE_RIGHT;
      MODE_LL: begin
        shape  = SHAPE_LEFT;
        mirror = 1'b1;
      end
      MODE_LR: begin
        shape  = SHAPE_RIGHT;
        mirror = 1'b1;
      end
      MODE_TOP:    shape = SHAPE_CENTER;
      MODE_BOTTOM: begin
        shape  = SHAPE_CENTER;
        mirror = 1'b1;
      end
      MODE_LEFT: begin
        shape    = SHAPE_LEFT;
        sel_left = 1'b1;
      end
      MODE_RIGHT: begin
        shape    = SHAPE_RIGHT;
        sel_left = 1'b1;
      end
      MODE_FULL: begin
        shape    = SHAPE_FULL;
        sel_full = 1'b1;
      end
      default:     bad_mode = 1'b1;
    endcase

    yf = h_i - COORD_BITS'(1) - row_i;
    yy = mirror ? yf : row_i;

    // One shared multiplier forms D for every shape.
    if (sel_full) begin
      op_a = {row_i, 1'b1};
      op_b = {h_i - row_i, 1'b0} - OW'(1);
    end else if (sel_left) begin
      op_a = {1'b0, row_i};
      op_b = {1'b0, h_i - row_i};
    end else begin
      op_a = {1'b0, h_i - yy};
      op_b = {1'b0, h_i} + {1'b0, yy};
    end
    prod = op_a * op_b;
    d_d  = sel_left ? {prod[DW-3:0], 2'b00} : prod[DW-1:0];

    ww_d = w_i * w_i;
    wh_d = w_i * h_i;

    side_d.shape = shape;
    side_d.empty = bad_mode || (w_i == '0) || (h_i == '0) || (row_i >= h_i);
    side_d.inv   = invert_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q <= side_d;
      s1_d_q    <= d_d;
      s1_ww_q   <= ww_d;
      s1_wh_q   <= wh_d;
      s2_side_q <= s1_side_q;
      s2_x_q    <= s1_ww_q * s1_d_q;
      s2_wh_q   <= s1_wh_q;
    end
  end

  assign valid_o = s2_valid_q;
  assign side_o  = s2_side_q;
  assign x_o     = s2_x_q;
  assign wh_o    = s2_wh_q;

endmodule

// ===== design/ets_isqrt.sv =====
// ----------------------------------------------------------------------------
// ets_isqrt: pipelined integer square root
// Digit-by-digit root, one result bit per stage, with a flag that tells
// whether the radicand was a perfect square.
// ----------------------------------------------------------------------------
module ets_isqrt #(
  parameter int unsigned COORD_BITS = ets_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ets_pkg::side_t          side_i,
  input  logic [4*COORD_BITS-1:0] x_i,
  input  logic [2*COORD_BITS-1:0] wh_i,
  output logic                    valid_o,
  output ets_pkg::side_t          side_o,
  output logic [2*COORD_BITS-1:0] root_o,
  output logic                    exact_o,
  output logic [2*COORD_BITS-1:0] wh_o
);
  import ets_pkg::*;

  localparam int unsigned RW = 2 * COORD_BITS;
  localparam int unsigned XW = 4 * COORD_BITS;

  logic [RW-1:0] valid_q;
  side_t         side_q [RW];
  logic [RW-1:0] wh_q   [RW];
  logic [RW-1:0] root_q [RW];
  logic [RW+1:0] rem_q  [RW];
  logic [XW-1:0] xs_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic          prev_valid;
    side_t         prev_side;
    logic [RW-1:0] prev_wh, prev_root;
    logic [RW+1:0] prev_rem, rem_sh, trial, rem_n;
    logic [XW-1:0] prev_xs;
    logic          ge;

    if (k == 0) begin : g_first
      assign prev_valid = valid_i;
      assign prev_side  = side_i;
      assign prev_wh    = wh_i;
      assign prev_root  = '0;
      assign prev_rem   = '0;
      assign prev_xs    = x_i;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign prev_side  = side_q[k-1];
      assign prev_wh    = wh_q[k-1];
      assign prev_root  = root_q[k-1];
      assign prev_rem   = rem_q[k-1];
      assign prev_xs    = xs_q[k-1];
    end

    // The remainder never exceeds twice the partial root, so its top two
    // bits are clear before the shift.
    always_comb begin
      rem_sh = {prev_rem[RW-1:0], prev_xs[XW-1:XW-2]};
      trial  = {prev_root, 2'b01};
      ge     = rem_sh >= trial;
      rem_n  = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= prev_side;
        wh_q[k]   <= prev_wh;
        root_q[k] <= {prev_root[RW-2:0], ge};
        rem_q[k]  <= rem_n;
        xs_q[k]   <= {prev_xs[XW-3:0], 2'b00};
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign side_o  = side_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign exact_o = (rem_q[RW-1] == '0);
  assign wh_o    = wh_q[RW-1];

endmodule

// ===== design/ets_div.sv =====
// ----------------------------------------------------------------------------
// ets_div: pipelined two-lane restoring divider
// Divides two numerators by a shared divisor, one quotient bit per stage,
// most significant bit first. Quotients fit in COORD_BITS bits.
// ----------------------------------------------------------------------------
module ets_div #(
  parameter int unsigned COORD_BITS = ets_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ets_pkg::side_t          side_i,
  input  logic [2*COORD_BITS+1:0] num_a_i,
  input  logic [2*COORD_BITS+1:0] num_b_i,
  input  logic [COORD_BITS:0]     div_i,
  output logic                    valid_o,
  output ets_pkg::side_t          side_o,
  output logic [COORD_BITS-1:0]   quo_a_o,
  output logic [COORD_BITS-1:0]   quo_b_o
);
  import ets_pkg::*;

  localparam int unsigned NW = 2 * COORD_BITS + 2;
  localparam int unsigned QW = COORD_BITS;

  logic [QW-1:0]     valid_q;
  side_t             side_q  [QW];
  logic [QW:0]       div_q   [QW];
  logic [NW-1:0]     rem_a_q [QW];
  logic [NW-1:0]     rem_b_q [QW];
  logic [QW-1:0]     quo_a_q [QW];
  logic [QW-1:0]     quo_b_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - k;
    logic          prev_valid;
    side_t         prev_side;
    logic [QW:0]   prev_div;
    logic [NW-1:0] prev_rem_a, prev_rem_b, dsh;
    logic [QW-1:0] prev_quo_a, prev_quo_b;
    logic          ge_a, ge_b;

    if (k == 0) begin : g_first
      assign prev_valid = valid_i;
      assign prev_side  = side_i;
      assign prev_div   = div_i;
      assign prev_rem_a = num_a_i;
      assign prev_rem_b = num_b_i;
      assign prev_quo_a = '0;
      assign prev_quo_b = '0;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign prev_side  = side_q[k-1];
      assign prev_div   = div_q[k-1];
      assign prev_rem_a = rem_a_q[k-1];
      assign prev_rem_b = rem_b_q[k-1];
      assign prev_quo_a = quo_a_q[k-1];
      assign prev_quo_b = quo_b_q[k-1];
    end

    always_comb begin
      dsh  = NW'(prev_div) << Bit;
      ge_a = prev_rem_a >= dsh;
      ge_b = prev_rem_b >= dsh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k]  <= prev_side;
        div_q[k]   <= prev_div;
        rem_a_q[k] <= ge_a ? prev_rem_a - dsh : prev_rem_a;
        rem_b_q[k] <= ge_b ? prev_rem_b - dsh : prev_rem_b;
        quo_a_q[k] <= {prev_quo_a[QW-2:0], ge_a};
        quo_b_q[k] <= {prev_quo_b[QW-2:0], ge_b};
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign side_o  = side_q[QW-1];
  assign quo_a_o = quo_a_q[QW-1];
  assign quo_b_o = quo_b_q[QW-1];

endmodule

// ===== design/ellipse_tile_row_span_core.sv =====
// ----------------------------------------------------------------------------
// ellipse_tile_row_span_core: span of one tile row inside an ellipse shape
// Top level: configuration registers, numerator stage, span stage, output
// register and the common pipeline advance.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries a mode, a row within the tile and an invert flag.
// Each output beat carries the half-open column span [start, end) inside
// the chosen shape and the pixel value to draw there.
// The tile width and height are written on the configuration port (index 0
// width, index 1 height); the user must do so only while no beat is in
// flight, as the block does not enforce it. cfg_ready_o is always high.
// Both reset to 64. The pipeline is two operand stages, one stage per root
// bit of the 2*COORD_BITS-bit square root, a numerator stage, one stage per
// quotient bit of the divider and the output register.
// One beat enters per cycle unless in_stall_o is high. When the output register holds a beat and
// out_stall_i is high the whole pipeline holds and in_stall_o is raised;
// nothing is dropped or repeated. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module ellipse_tile_row_span_core #(
  parameter int unsigned COORD_BITS = ets_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [3:0]                          mode_i,
  input  logic [COORD_BITS-1:0]               row_in_tile_i,
  input  logic                                invert_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [COORD_BITS-1:0]               span_start_o,
  output logic [COORD_BITS-1:0]               span_end_o,
  output logic                                inside_value_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ets_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [COORD_BITS-1:0]               cfg_data_i
);
  import ets_pkg::*;

  localparam int unsigned DW = 2 * COORD_BITS;
  localparam int unsigned XW = 4 * COORD_BITS;
  localparam int unsigned NW = 2 * COORD_BITS + 2;

  logic [COORD_BITS-1:0] w_q, h_q;
  logic                  en;

  logic                  fr_valid;
  side_t                 fr_side;
  logic [XW-1:0]         fr_x;
  logic [DW-1:0]         fr_wh;

  logic                  sq_valid, sq_exact;
  side_t                 sq_side;
  logic [DW-1:0]         sq_root, sq_wh;

  logic [DW:0]           ceil_root;
  logic [NW-1:0]         num_a_d, num_b_d;
  logic [COORD_BITS:0]   div_d;
  logic                  nm_valid_q;
  side_t                 nm_side_q;
  logic [NW-1:0]         num_a_q, num_b_q;
  logic [COORD_BITS:0]   div_q;

  logic                  dv_valid;
  side_t                 dv_side;
  logic [COORD_BITS-1:0] quo_a, quo_b;

  logic [COORD_BITS-1:0] start_d, end_d;
  logic                  out_valid_q, inside_q;
  logic [COORD_BITS-1:0] start_q, end_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= COORD_BITS'(TILE_WIDTH_RST);
      h_q <= COORD_BITS'(TILE_HEIGHT_RST);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TILE_WIDTH) begin
        w_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_TILE_HEIGHT) begin
        h_q <= cfg_data_i;
      end
    end
  end

  ets_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .mode_i   (mode_i),
    .row_i    (row_in_tile_i),
    .invert_i (invert_i),
    .w_i      (w_q),
    .h_i      (h_q),
    .valid_o  (fr_valid),
    .side_o   (fr_side),
    .x_o      (fr_x),
    .wh_o     (fr_wh)
  );

  ets_isqrt #(.COORD_BITS(COORD_BITS)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .x_i     (fr_x),
    .wh_i    (fr_wh),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (sq_root),
    .exact_o (sq_exact),
    .wh_o    (sq_wh)
  );

  // The full ellipse needs the ceiling of the root and two quotients by 2h;
  // the other shapes divide the floor of the root by h or 2h.
  always_comb begin
    ceil_root = {1'b0, sq_root} + (DW + 1)'(!sq_exact);
    num_b_d   = NW'(sq_wh) + NW'(ceil_root) + NW'({h_q, 1'b0}) - NW'(1);
    if (sq_side.shape == SHAPE_FULL) begin
      num_a_d = NW'(sq_wh) - NW'(ceil_root);
    end else begin
      num_a_d = NW'(sq_root);
    end
    if (sq_side.shape == SHAPE_CENTER || sq_side.shape == SHAPE_FULL) begin
      div_d = {h_q, 1'b0};
    end else begin
      div_d = {1'b0, h_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_valid_q <= 1'b0;
    end else if (en) begin
      nm_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm_side_q <= sq_side;
      num_a_q   <= num_a_d;
      num_b_q   <= num_b_d;
      div_q     <= div_d;
    end
  end

  ets_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_valid_q),
    .side_i  (nm_side_q),
    .num_a_i (num_a_q),
    .num_b_i (num_b_q),
    .div_i   (div_q),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b)
  );

  always_comb begin
    start_d = '0;
    end_d   = '0;
    if (!dv_side.empty) begin
      unique case (dv_side.shape)
        SHAPE_LEFT: begin
          start_d = '0;
          end_d   = quo_a;
        end
        SHAPE_RIGHT: begin
          start_d = w_q - quo_a;
          end_d   = w_q;
        end
        SHAPE_CENTER: begin
          start_d = quo_a;
          end_d   = w_q - quo_a;
        end
        SHAPE_FULL: begin
          start_d = quo_a;
          end_d   = quo_b;
        end
        default: begin
          start_d = '0;
          end_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      start_q  <= start_d;
      end_q    <= end_d;
      inside_q <= !dv_side.inv;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign span_start_o   = start_q;
  assign span_end_o     = end_q;
  assign inside_value_o = inside_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ellipse tile row span core
// Drives tile rows in every shape mode through several tile sizes, predicts
// the inside span of each row with exact integer roots, and compares every
// output beat in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import ets_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 3 * CB + 10;

  typedef struct {
    logic [CB-1:0] start;
    logic [CB-1:0] stop;
    logic          value;
  } span_t;

  class span_scoreboard;
    span_t       pending[$];
    logic [CB-1:0] width;
    logic [CB-1:0] height;
    int unsigned errors;

    function new();
      width = CB'(TILE_WIDTH_RST);
      height = CB'(TILE_HEIGHT_RST);
      errors = 0;
    endfunction

    task report(string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    static function longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function span_t predict(logic [3:0] m, logic [CB-1:0] row, logic inv);
      longint unsigned w, h, y, yf, s, e, t, d, x, r, c, dv;
      span_t res;
      w = width;
      h = height;
      y = row;
      s = 0;
      e = 0;
      if (w != 0 && h != 0 && y < h) begin
        yf = h - 1 - y;
        case (m)
          MODE_UL:     e = root_floor(w * w * (h - y) * (h + y)) / h;
          MODE_UR: begin
            s = w - root_floor(w * w * (h - y) * (h + y)) / h;
            e = w;
          end
          MODE_LL:     e = root_floor(w * w * (h - yf) * (h + yf)) / h;
          MODE_LR: begin
            s = w - root_floor(w * w * (h - yf) * (h + yf)) / h;
            e = w;
          end
          MODE_TOP: begin
            t = root_floor(w * w * (h - y) * (h + y)) / (2 * h);
            s = t;
            e = w - t;
          end
          MODE_BOTTOM: begin
            t = root_floor(w * w * (h - yf) * (h + yf)) / (2 * h);
            s = t;
            e = w - t;
          end
          MODE_LEFT:   e = root_floor(w * w * 4 * y * (h - y)) / h;
          MODE_RIGHT: begin
            s = w - root_floor(w * w * 4 * y * (h - y)) / h;
            e = w;
          end
          MODE_FULL: begin
            // Round the root up so the span covers every partly inside pixel.
            d = (2 * y + 1) * (2 * h - 2 * y - 1);
            x = w * w * d;
            r = root_floor(x);
            c = (r * r == x) ? r : r + 1;
            dv = 2 * h;
            s = (w * h - c) / dv;
            e = (w * h + c + dv - 1) / dv;
          end
          default: begin
            s = 0;
            e = 0;
          end
        endcase
      end
      res.start = s[CB-1:0];
      res.stop = e[CB-1:0];
      res.value = ~inv;
      return res;
    endfunction

    function void note_row(logic [3:0] m, logic [CB-1:0] row, logic inv);
      pending.push_back(predict(m, row, inv));
    endfunction

    task check_span(logic [CB-1:0] start, logic [CB-1:0] stop, logic value);
      span_t exp_span;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat start=%0d end=%0d", start, stop));
      end else begin
        exp_span = pending.pop_front();
        if (start !== exp_span.start || stop !== exp_span.stop
            || value !== exp_span.value)
          report($sformatf("got [%0d,%0d) v%0d, want [%0d,%0d) v%0d (w=%0d h=%0d)",
                           start, stop, value, exp_span.start, exp_span.stop,
                           exp_span.value, width, height));
      end
    endtask
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [3:0]    mode_i = 4'd0;
  logic [CB-1:0] row_in_tile_i = '0;
  logic          invert_i = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [CB-1:0] span_start_o;
  logic [CB-1:0] span_end_o;
  logic          inside_value_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [CB-1:0] cfg_data_i = '0;

  span_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles = 0;

  always #2 clk_i = ~clk_i;

  ellipse_tile_row_span_core #(.COORD_BITS(CB)) dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Output side: check with pre-edge values, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_span(span_start_o, span_end_o, inside_value_o);
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < recv_stall_pct);
  end

  task send_row(logic [3:0] m, logic [CB-1:0] row, logic inv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    row_in_tile_i <= row;
    invert_i <= inv;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_row(m, row, inv);
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high so that writes can follow back to back.
  task write_reg(reg_idx_e idx, logic [CB-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_TILE_WIDTH) sb.width = data;
    else sb.height = data;
  endtask

  task set_tile(logic [CB-1:0] w, logic [CB-1:0] h);
    wait_drained();
    write_reg(REG_TILE_WIDTH, w);
    write_reg(REG_TILE_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task random_rows(int unsigned n);
    logic [CB-1:0] row;
    for (int unsigned i = 0; i < n; i++) begin
      // Mostly rows inside the tile; the rest anywhere in the field.
      if (sb.height != 0 && $urandom_range(0, 9) < 8)
        row = CB'($urandom_range(0, sb.height - 1));
      else
        row = CB'($urandom());
      send_row(4'($urandom_range(0, 15)), row, 1'($urandom()));
    end
  endtask

  logic [CB-1:0] tile_w[10] = '{12'd64, 12'd1, 12'd4095, 12'd0, 12'd64,
                                12'd4095, 12'd1, 12'd7, 12'd640, 12'd33};
  logic [CB-1:0] tile_h[10] = '{12'd64, 12'd1, 12'd4095, 12'd64, 12'd0,
                                12'd1, 12'd4095, 12'd5, 12'd480, 12'd2};

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset tile size: every mode at both edge rows.
    for (int m = 0; m <= 8; m++) begin
      send_row(4'(m), 12'd0, 1'b0);
      send_row(4'(m), 12'd63, 1'b1);
    end
    send_row(4'd15, 12'd5, 1'b0);
    send_row(MODE_FULL, 12'd64, 1'b1);
    send_row(MODE_UL, 12'd4095, 1'b0);
    send_row(MODE_LEFT, 12'd32, 1'b1);

    for (int p = 0; p < 10; p++) begin
      set_tile(tile_w[p], tile_h[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      random_rows(60);
      // Hold the sender until the pipeline has fully emptied once per phase.
      in_valid_i <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clk_i);
      random_rows(60);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      if (sb.pending.size() != 0)
        $display("tb: %0d expected beats never arrived", sb.pending.size());
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/ets_pkg.sv
design/ets_front.sv
design/ets_isqrt.sv
design/ets_div.sv
design/ellipse_tile_row_span_core.sv
tb/tb.sv
